/* hw/rtl/smk_pkg.sv */
package smk_pkg;

  localparam int unsigned AdcW   = 8;
  localparam int unsigned PctW   = 7;
  localparam int unsigned SecW   = 8;
  localparam int unsigned ChanW  = 2;
  localparam int unsigned LevelW = 3;
  localparam int unsigned LinesW = 4;
  localparam int unsigned CmpW   = 15;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;

  localparam logic [CmpW-1:0] PctScale = 15'd100;
  localparam logic [PctW-1:0] FanLim4  = 7'd70;
  localparam logic [PctW-1:0] FanLim3  = 7'd60;
  localparam logic [PctW-1:0] FanLim2  = 7'd50;
  localparam logic [SecW-1:0] SecMax   = 8'd255;

  localparam logic [PctW-1:0] AlarmThrRst = 7'd10;
  localparam logic [PctW-1:0] FanThrRst   = 7'd20;
  localparam logic [SecW-1:0] WarnSecRst  = 8'd10;
  localparam logic [SecW-1:0] SleepSecRst = 8'd10;
  localparam logic [SecW-1:0] TicksRst    = 8'd20;

  typedef enum logic {
    ModeSample = 1'b0,
    ModeTick   = 1'b1
  } mode_e;

  typedef enum logic [2:0] {
    RegAlarmThr  = 3'd0,
    RegFanThr    = 3'd1,
    RegWarnSec   = 3'd2,
    RegSleepSec  = 3'd3,
    RegTicksSec  = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [PctW-1:0] alarm_threshold;
    logic [PctW-1:0] fan_threshold;
    logic [SecW-1:0] warning_seconds;
    logic [SecW-1:0] sleep_seconds;
    logic [SecW-1:0] ticks_per_second;
  } cfg_t;

  typedef struct packed {
    mode_e            mode;
    logic [ChanW-1:0] channel;
    logic [AdcW-1:0]  adc_value;
  } item_t;

  // packed MSB first: alarm_lines ends up in the lowest bits
  typedef struct packed {
    logic              second_elapsed;
    logic [LevelW-1:0] fan_level;
    logic [ChanW-1:0]  channel_out;
    logic [LinesW-1:0] alarm_lines;
  } result_t;

  localparam int unsigned ResultW = $bits(result_t);

  // exact compare of adc*100 against pct*256
  function automatic logic above(input logic [AdcW-1:0] adc, input logic [PctW-1:0] pct);
    logic [CmpW-1:0] lhs;
    logic [CmpW-1:0] rhs;
    lhs = {{(CmpW-AdcW){1'b0}}, adc} * PctScale;
    rhs = {pct, {AdcW{1'b0}}};
    return lhs > rhs;
  endfunction

endpackage

/* hw/rtl/smoke_alarm_cadence_fan_level.sv */
// Four-channel smoke alarm controller. Each transfer on the input stream is
// either a sample (tuser 0: channel and 8-bit reading) or a timer tick
// (tuser 1), and gives exactly one result transfer: the alarm lines of all
// channels after the item, the sampled channel and its fan level 0..4, and a
// flag when a tick completed a second. One item is taken every clock cycle
// while results are accepted; an item passes the input register, then the
// result register; the per-channel counters update as the result is registered.
// Settings live in the APB registers: 0x00 alarm threshold, 0x04 fan
// threshold, 0x08 warning seconds, 0x0C sleep seconds, 0x10 ticks per second.
module smoke_alarm_cadence_fan_level #(
  parameter int unsigned CHANNELS = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [15:0]               s_axis_tdata,  // channel[1:0], adc_value[9:2], zero
  input  logic                      s_axis_tuser,  // mode
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [15:0]               m_axis_tdata,  // alarm_lines[3:0], channel_out[5:4],
                                                   // fan_level[8:6], second_elapsed[9], zero
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [smk_pkg::AddrW-1:0] paddr,
  input  logic [smk_pkg::DataW-1:0] pwdata,
  output logic [smk_pkg::DataW-1:0] prdata,
  output logic                      pready
);

  smk_pkg::cfg_t    cfg;
  smk_pkg::item_t   in_item_q, in_item_d;
  smk_pkg::result_t res, out_res_q;
  logic             in_valid_q, in_valid_d;
  logic             out_valid_q, out_valid_d;
  logic             advance;
  logic             in_xfer;

  smk_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  smk_core #(
    .CHANNELS (CHANNELS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .item_i   (in_item_q),
    .cfg_i    (cfg),
    .result_o (res)
  );

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  assign in_valid_d  = in_xfer || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && !m_axis_tready);

  assign in_item_d.mode      = smk_pkg::mode_e'(s_axis_tuser);
  assign in_item_d.channel   = s_axis_tdata[1:0];
  assign in_item_d.adc_value = s_axis_tdata[9:2];

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(16-smk_pkg::ResultW){1'b0}}, out_res_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_item_q <= in_item_d;
    end
    if (advance) begin
      out_res_q <= res;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_res_q.second_elapsed |->
      out_res_q.channel_out == '0 && out_res_q.fan_level == '0)
    else $error("second flag on a result that carries sample data");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_res_q.fan_level <= 3'd4)
    else $error("fan level out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("processed item produced no result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready |=> out_valid_q && $stable(out_res_q))
    else $error("stalled result changed or dropped");

endmodule

/* hw/rtl/smk_cfg.sv */
module smk_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [smk_pkg::AddrW-1:0]   paddr,
  input  logic [smk_pkg::DataW-1:0]   pwdata,
  output logic [smk_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  output smk_pkg::cfg_t               cfg_o
);

  smk_pkg::cfg_t      cfg_q, cfg_d;
  smk_pkg::reg_idx_e  idx;
  logic               wr_en;

  assign idx    = smk_pkg::reg_idx_e'(paddr[smk_pkg::AddrW-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        smk_pkg::RegAlarmThr: cfg_d.alarm_threshold  = pwdata[smk_pkg::PctW-1:0];
        smk_pkg::RegFanThr:   cfg_d.fan_threshold    = pwdata[smk_pkg::PctW-1:0];
        smk_pkg::RegWarnSec:  cfg_d.warning_seconds  = pwdata[smk_pkg::SecW-1:0];
        smk_pkg::RegSleepSec: cfg_d.sleep_seconds    = pwdata[smk_pkg::SecW-1:0];
        smk_pkg::RegTicksSec: cfg_d.ticks_per_second = pwdata[smk_pkg::SecW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      smk_pkg::RegAlarmThr: prdata[smk_pkg::PctW-1:0] = cfg_q.alarm_threshold;
      smk_pkg::RegFanThr:   prdata[smk_pkg::PctW-1:0] = cfg_q.fan_threshold;
      smk_pkg::RegWarnSec:  prdata[smk_pkg::SecW-1:0] = cfg_q.warning_seconds;
      smk_pkg::RegSleepSec: prdata[smk_pkg::SecW-1:0] = cfg_q.sleep_seconds;
      smk_pkg::RegTicksSec: prdata[smk_pkg::SecW-1:0] = cfg_q.ticks_per_second;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alarm_threshold  <= smk_pkg::AlarmThrRst;
      cfg_q.fan_threshold    <= smk_pkg::FanThrRst;
      cfg_q.warning_seconds  <= smk_pkg::WarnSecRst;
      cfg_q.sleep_seconds    <= smk_pkg::SleepSecRst;
      cfg_q.ticks_per_second <= smk_pkg::TicksRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

/* hw/rtl/smk_core.sv */
module smk_core #(
  parameter int unsigned CHANNELS = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  smk_pkg::item_t   item_i,
  input  smk_pkg::cfg_t    cfg_i,
  output smk_pkg::result_t result_o
);

  logic [smk_pkg::SecW-1:0]   on_q  [CHANNELS];
  logic [smk_pkg::SecW-1:0]   on_d  [CHANNELS];
  logic [smk_pkg::SecW-1:0]   off_q [CHANNELS];
  logic [smk_pkg::SecW-1:0]   off_d [CHANNELS];
  logic [CHANNELS-1:0]        alarm_q, alarm_d;
  logic [smk_pkg::SecW-1:0]   tick_q, tick_d;
  logic [smk_pkg::SecW-1:0]   tick_inc;
  logic                       alarm_hit;
  logic                       chan_ok;
  logic                       sec;
  logic [smk_pkg::LevelW-1:0] fan;

  assign tick_inc  = tick_q + 8'd1;
  assign alarm_hit = smk_pkg::above(item_i.adc_value, cfg_i.alarm_threshold);
  assign chan_ok   = int'(item_i.channel) < CHANNELS;

  always_comb begin
    fan = 3'd0;
    if (item_i.mode == smk_pkg::ModeSample && chan_ok &&
        smk_pkg::above(item_i.adc_value, cfg_i.fan_threshold)) begin
      priority if (smk_pkg::above(item_i.adc_value, smk_pkg::FanLim4)) fan = 3'd4;
      else if (smk_pkg::above(item_i.adc_value, smk_pkg::FanLim3)) fan = 3'd3;
      else if (smk_pkg::above(item_i.adc_value, smk_pkg::FanLim2)) fan = 3'd2;
      else fan = 3'd1;
    end
  end

  always_comb begin
    on_d    = on_q;
    off_d   = off_q;
    alarm_d = alarm_q;
    tick_d  = tick_q;
    sec     = 1'b0;
    if (item_i.mode == smk_pkg::ModeTick) begin
      tick_d = tick_inc;
      if (tick_inc == cfg_i.ticks_per_second) begin
        tick_d = '0;
        sec    = 1'b1;
        for (int i = 0; i < CHANNELS; i++) begin
          if (on_q[i] != '0 && on_q[i] != smk_pkg::SecMax) on_d[i] = on_q[i] + 8'd1;
          if (off_q[i] != '0 && off_q[i] != smk_pkg::SecMax) off_d[i] = off_q[i] + 8'd1;
        end
      end
    end else begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (int'(item_i.channel) == i) begin
          if (!alarm_hit) begin
            alarm_d[i] = 1'b0;
            on_d[i]    = '0;
            off_d[i]   = '0;
          end else if (on_q[i] == '0 && off_q[i] == '0) begin
            alarm_d[i] = 1'b1;
            on_d[i]    = 8'd1;
          end else begin
            if (on_q[i] >= cfg_i.warning_seconds) begin
              on_d[i]    = '0;
              off_d[i]   = 8'd1;
              alarm_d[i] = 1'b0;
            end
            if (off_d[i] >= cfg_i.sleep_seconds) begin
              off_d[i]   = '0;
              alarm_d[i] = 1'b1;
              on_d[i]    = 8'd1;
            end
          end
        end
      end
    end
  end

  always_comb begin
    result_o = '0;
    for (int i = 0; i < smk_pkg::LinesW; i++) begin
      if (i < CHANNELS) result_o.alarm_lines[i] = alarm_d[i];
    end
    result_o.channel_out    = (item_i.mode == smk_pkg::ModeSample) ? item_i.channel : '0;
    result_o.fan_level      = fan;
    result_o.second_elapsed = sec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        on_q[i]  <= '0;
        off_q[i] <= '0;
      end
      alarm_q <= '0;
      tick_q  <= '0;
    end else if (en_i) begin
      on_q    <= on_d;
      off_q   <= off_d;
      alarm_q <= alarm_d;
      tick_q  <= tick_d;
    end
  end

endmodule
